// ===== hdl/pat_pkg.sv =====
// shared types and codes for the positional array table
// no dependencies; compiled before the interfaces and modules
package pat_pkg;

  localparam logic [2:0] KIND_CLEAR  = 3'd0;
  localparam logic [2:0] KIND_INSERT = 3'd1;
  localparam logic [2:0] KIND_DELETE = 3'd2;
  localparam logic [2:0] KIND_SEARCH = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_BADPOS = 2'd1;
  localparam logic [1:0] STATUS_FULL   = 2'd2;
  localparam logic [1:0] STATUS_MISS   = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INSERT,
    CM_DELETE,
    CM_ROTATE
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t  mode;
    logic [31:0] value;
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  found_index;
    logic [31:0] read_value;
    logic [6:0]  count;
  } res_t;

endpackage

// ===== hdl/pat_if.sv =====
// valid/ready channel interfaces for requests and responses
// depends on nothing; field widths follow the table's item layout
interface pat_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [6:0]         position;
  logic signed [31:0] value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface

interface pat_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [5:0]         found_index;
  logic signed [31:0] read_value;
  logic [6:0]         count;

  modport source (output valid, status, found_index, read_value, count, input ready);
  modport sink   (input valid, status, found_index, read_value, count, output ready);
endinterface

// ===== hdl/pat_cell.sv =====
// one storage cell of the table chain
// depends on pat_pkg for the broadcast control struct
module pat_cell #(
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic                clk,
  input  pat_pkg::cell_ctl_t  ctl,
  input  logic [IW-1:0]       idx,
  input  logic [31:0]         left,
  input  logic [31:0]         right,
  output logic [31:0]         value
);
  import pat_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  always_ff @(posedge clk) begin
    case (ctl.mode)
      CM_INSERT: begin
        if (MY_IDX > idx) begin
          value <= left;
        end else if (MY_IDX == idx) begin
          value <= ctl.value;
        end
      end
      CM_DELETE: begin
        if (MY_IDX >= idx) begin
          value <= right;
        end
      end
      CM_ROTATE: value <= right;
      default: ;
    endcase
  end

endmodule

// ===== hdl/positional_array_table_core.sv =====
// top level of the positional array table: cell chain, sequencer, response queue
// depends on pat_pkg, pat_req_if / pat_rsp_if and pat_cell
//
// clear, insert, delete and rejected requests: the response is queued at the
// accepting edge and shows on rsp the next cycle if no older response waits
// search and good reads: the chain rotates once around all DEPTH cells,
// cell 0 is inspected each cycle; the response is queued on the last step
// a two-entry response queue lets a request be taken while a response waits
// synchronous active-high reset empties the table and the queue; no clearing pass
module positional_array_table_core #(
  parameter int DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  pat_req_if.sink    req,
  pat_rsp_if.source  rsp
);
  import pat_pkg::*;

  // widths derived from the depth
  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = ((CW > 7) ? CW : 7) + 1;
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);
  localparam logic [MW-1:0] FULL_COUNT = MW'(DEPTH);

  // control state
  state_t          state, state_next;
  logic [CW-1:0]   count, count_next;

  // scan registers
  logic            scan_search;
  logic [6:0]      scan_pos;
  logic [31:0]     scan_val;
  logic [IW-1:0]   scan_k;
  logic            hit;
  logic [IW-1:0]   hit_index;
  logic [31:0]     rd_data;

  // response queue
  res_t            q_res [2];
  logic            wr_ptr, rd_ptr;
  logic [1:0]      fill;

  // chain wiring
  logic [31:0]     vals [DEPTH];
  cell_ctl_t       ctl;
  logic [IW-1:0]   cell_idx;
  logic [31:0]     head;

  logic            accept, pop, push;
  res_t            res;
  logic [MW-1:0]   pos_ext, cnt_ext, k_ext, found_ext, scan_pos_ext;
  logic            hit_now, rd_now;

  assign head         = vals[0];
  assign pos_ext      = MW'(req.position);
  assign cnt_ext      = MW'(count);
  assign k_ext        = MW'(scan_k);
  assign scan_pos_ext = MW'(scan_pos);

  assign req.ready = (state == ST_IDLE) && (fill != 2'd2);
  assign accept    = req.valid && req.ready;
  assign pop       = rsp.valid && rsp.ready;

  // match at the head cell, only over occupied entries
  assign hit_now = (k_ext < cnt_ext) && (head == scan_val);
  assign rd_now  = (k_ext == scan_pos_ext);

  // cell chain: left neighbour feeds inserts, right neighbour deletes and rotation
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    pat_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .idx   (cell_idx),
      .left  (vals[(i + DEPTH - 1) % DEPTH]),
      .right (vals[(i + 1) % DEPTH]),
      .value (vals[i])
    );
  end

  // sequencer: next state, chain command and response
  always_comb begin
    state_next  = state;
    count_next  = count;
    ctl.mode    = CM_HOLD;
    ctl.value   = req.value;
    cell_idx    = IW'(pos_ext - MW'(1));
    push        = 1'b0;
    res         = '0;
    found_ext   = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          push       = 1'b1;
          res.status = STATUS_OK;
          case (req.kind)
            KIND_CLEAR: count_next = '0;
            KIND_INSERT: begin
              if ((req.position == 7'd0) || (pos_ext > cnt_ext + MW'(1))) begin
                res.status = STATUS_BADPOS;
              end else if (cnt_ext == FULL_COUNT) begin
                res.status = STATUS_FULL;
              end else begin
                ctl.mode   = CM_INSERT;
                count_next = count + CW'(1);
              end
            end
            KIND_DELETE: begin
              if ((req.position == 7'd0) || (pos_ext > cnt_ext)) begin
                res.status = STATUS_BADPOS;
              end else begin
                ctl.mode   = CM_DELETE;
                count_next = count - CW'(1);
              end
            end
            KIND_SEARCH: begin
              push       = 1'b0;
              state_next = ST_SCAN;
            end
            KIND_READ: begin
              if (pos_ext < cnt_ext) begin
                push       = 1'b0;
                state_next = ST_SCAN;
              end else begin
                res.status = STATUS_BADPOS;
              end
            end
            default: res.status = STATUS_BADPOS;
          endcase
          res.count = 7'(count_next);
        end
      end
      ST_SCAN: begin
        // one rotation step per cycle; full turn restores the order
        ctl.mode = CM_ROTATE;
        if (scan_k == LAST) begin
          push       = 1'b1;
          state_next = ST_IDLE;
          res.count  = 7'(cnt_ext);
          if (scan_search) begin
            if (hit || hit_now) begin
              res.status      = STATUS_OK;
              found_ext       = hit ? MW'(hit_index) : k_ext;
              res.found_index = found_ext[5:0];
            end else begin
              res.status = STATUS_MISS;
            end
          end else begin
            res.status     = STATUS_OK;
            res.read_value = rd_now ? head : rd_data;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_k <= '0;
      hit    <= 1'b0;
    end else if (state == ST_IDLE) begin
      scan_k <= '0;
      hit    <= 1'b0;
    end else begin
      scan_k <= scan_k + IW'(1);
      if (hit_now && !hit) begin
        hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scan_search <= (req.kind == KIND_SEARCH);
      scan_pos    <= req.position;
      scan_val    <= req.value;
    end
    if ((state == ST_SCAN) && hit_now && !hit) begin
      hit_index <= scan_k;
    end
    if ((state == ST_SCAN) && rd_now) begin
      rd_data <= head;
    end
  end

  // two-entry response queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_res[wr_ptr] <= res;
    end
  end

  assign rsp.valid       = (fill != 2'd0);
  assign rsp.status      = q_res[rd_ptr].status;
  assign rsp.found_index = q_res[rd_ptr].found_index;
  assign rsp.read_value  = q_res[rd_ptr].read_value;
  assign rsp.count       = q_res[rd_ptr].count;

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3)
    else $error("response queue fill out of range");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (fill != 2'd2) || pop)
    else $error("response pushed into a full queue");

  a_busy_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !req.ready)
    else $error("request taken during a scan");

  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && scan_k == LAST) |=> (state == ST_IDLE) && rsp.valid)
    else $error("scan did not finish with a response");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    MW'(count) <= FULL_COUNT)
    else $error("entry count above depth");

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for positional_array_table_core: directed table, then random traffic
// depends on pat_pkg and the pat_req_if / pat_rsp_if channel interfaces in hdl
`timescale 1ns / 100ps

module tb_top;
  import pat_pkg::*;

  localparam int DEPTH        = 64;
  localparam int N_DIRECTED   = 26;
  localparam int RANDOM_ITEMS = 950;
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off in the last phase
  localparam int STALL_LIMIT  = 3000;  // cycles with no transfer on either channel

  // kinds the block does not implement; they must be rejected as bad position
  localparam logic [2:0] KIND_RSVD5 = 3'd5;
  localparam logic [2:0] KIND_RSVD6 = 3'd6;
  localparam logic [2:0] KIND_RSVD7 = 3'd7;

  logic clk = 1'b0;
  logic rst;

  pat_req_if req_ch ();
  pat_rsp_if rsp_ch ();

  positional_array_table_core #(
    .DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the table, updated at every accepted request
  // ---------------------------------------------------------------------------
  logic [31:0] table_mem [DEPTH];
  int          table_len;

  res_t pending_rsp [$];   // responses still owed by the block, oldest first

  int errors        = 0;
  int items_sent    = 0;
  int rsp_checked   = 0;
  int full_rejects  = 0;
  int search_hits   = 0;
  int stall_cycles  = 0;

  // idle percentages for each side, changed by the stimulus process per phase
  int tx_idle_pct;
  int rx_idle_pct;

  // receiver hold-off, requested by the stimulus and counted down by the receiver
  bit hold_request = 1'b0;
  int hold_left    = 0;
  int holds_done   = 0;

  // values that recur often, so that searches hit and duplicates show up
  logic [31:0] value_pool [8] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
    32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_002A
  };

  // work out the response of one table operation and apply it to the shadow copy
  function automatic res_t predict_op(logic [2:0] kind, logic [6:0] pos, logic [31:0] val);
    res_t r;
    int   p;
    int   i;
    r = '0;
    r.status = STATUS_OK;
    p = int'(pos);
    case (kind)
      KIND_CLEAR: begin
        table_len = 0;
      end
      KIND_INSERT: begin
        // position is checked before the full condition
        if (p < 1 || p > table_len + 1) begin
          r.status = STATUS_BADPOS;
        end else if (table_len >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          for (i = table_len; i >= p; i--) table_mem[i] = table_mem[i - 1];
          table_mem[p - 1] = val;
          table_len++;
        end
      end
      KIND_DELETE: begin
        if (p < 1 || p > table_len) begin
          r.status = STATUS_BADPOS;
        end else begin
          for (i = p - 1; i + 1 < table_len; i++) table_mem[i] = table_mem[i + 1];
          table_len--;
        end
      end
      KIND_SEARCH: begin
        // lowest matching index wins
        r.status = STATUS_MISS;
        for (i = 0; i < table_len; i++) begin
          if (table_mem[i] == val) begin
            r.status = STATUS_OK;
            r.found_index = i[5:0];
            break;
          end
        end
      end
      KIND_READ: begin
        if (p < table_len) r.read_value = table_mem[p];
        else r.status = STATUS_BADPOS;
      end
      default: begin
        r.status = STATUS_BADPOS;
      end
    endcase
    r.count = table_len[6:0];
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 99) < 50) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // offer one request, wait for the transfer, then record what the block owes us
  task automatic send_item(input logic [2:0] kind, input logic [6:0] pos,
                           input logic [31:0] val, input bit typed = 1'b0,
                           input res_t typed_want = '0);
    res_t want;
    // random gap before the request, valid dropped for its duration
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.kind     <= kind;
    req_ch.position <= pos;
    req_ch.value    <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    // transfer happened at this edge; the shadow table moves on regardless
    want = predict_op(kind, pos, val);
    if (typed) want = typed_want;
    if (want.status == STATUS_FULL) full_rejects++;
    if (kind == KIND_SEARCH && want.status == STATUS_OK) search_hits++;
    pending_rsp.push_back(want);
    items_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // directed table: expectations typed in where they are obvious, else predicted
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [2:0]  kind;
    logic [6:0]  pos;
    logic [31:0] val;
    bit          typed;
    logic [1:0]  status;
    logic [5:0]  found;
    logic [31:0] rdval;
    logic [6:0]  count;
  } stim_row_t;

  stim_row_t dir_rows [N_DIRECTED] = '{
    // empty table after reset
    '{KIND_READ,   7'd0,   32'h0000_0000, 1'b1, STATUS_BADPOS, 6'd0, 32'h0, 7'd0},
    '{KIND_DELETE, 7'd1,   32'h0000_0000, 1'b1, STATUS_BADPOS, 6'd0, 32'h0, 7'd0},
    '{KIND_SEARCH, 7'd0,   32'h0000_0000, 1'b1, STATUS_MISS,   6'd0, 32'h0, 7'd0},
    // bad insert positions: zero, one past the end plus one, top of the field
    '{KIND_INSERT, 7'd0,   32'h0000_0005, 1'b1, STATUS_BADPOS, 6'd0, 32'h0, 7'd0},
    '{KIND_INSERT, 7'd2,   32'h0000_0005, 1'b1, STATUS_BADPOS, 6'd0, 32'h0, 7'd0},
    '{KIND_INSERT, 7'd127, 32'hFFFF_FFFF, 1'b1, STATUS_BADPOS, 6'd0, 32'h0, 7'd0},
    // fill with the value extremes, front and middle inserts
    '{KIND_INSERT, 7'd1,   32'h8000_0000, 1'b1, STATUS_OK,     6'd0, 32'h0, 7'd1},
    '{KIND_INSERT, 7'd2,   32'h7FFF_FFFF, 1'b1, STATUS_OK,     6'd0, 32'h0, 7'd2},
    '{KIND_INSERT, 7'd1,   32'hFFFF_FFFF, 1'b1, STATUS_OK,     6'd0, 32'h0, 7'd3},
    '{KIND_INSERT, 7'd2,   32'h0000_0000, 1'b0, 2'd0, 6'd0, 32'h0, 7'd0},
    // reads at both ends and past the end
    '{KIND_READ,   7'd0,   32'h0000_0000, 1'b1, STATUS_OK, 6'd0, 32'hFFFF_FFFF, 7'd4},
    '{KIND_READ,   7'd3,   32'h0000_0000, 1'b1, STATUS_OK, 6'd0, 32'h7FFF_FFFF, 7'd4},
    '{KIND_READ,   7'd4,   32'h0000_0000, 1'b1, STATUS_BADPOS, 6'd0, 32'h0, 7'd4},
    '{KIND_READ,   7'd127, 32'h0000_0000, 1'b1, STATUS_BADPOS, 6'd0, 32'h0, 7'd4},
    // search hit and miss, then an insert past the end
    '{KIND_SEARCH, 7'd0,   32'h8000_0000, 1'b0, 2'd0, 6'd0, 32'h0, 7'd0},
    '{KIND_SEARCH, 7'd0,   32'h1234_5678, 1'b0, 2'd0, 6'd0, 32'h0, 7'd0},
    '{KIND_INSERT, 7'd6,   32'h0000_0001, 1'b1, STATUS_BADPOS, 6'd0, 32'h0, 7'd4},
    // bad delete positions, then a middle and a last delete
    '{KIND_DELETE, 7'd0,   32'h0000_0000, 1'b1, STATUS_BADPOS, 6'd0, 32'h0, 7'd4},
    '{KIND_DELETE, 7'd5,   32'h0000_0000, 1'b1, STATUS_BADPOS, 6'd0, 32'h0, 7'd4},
    '{KIND_DELETE, 7'd2,   32'h0000_0000, 1'b0, 2'd0, 6'd0, 32'h0, 7'd0},
    '{KIND_DELETE, 7'd3,   32'h0000_0000, 1'b0, 2'd0, 6'd0, 32'h0, 7'd0},
    // unused kinds leave the table alone
    '{KIND_RSVD5,  7'd1,   32'h0000_0000, 1'b1, STATUS_BADPOS, 6'd0, 32'h0, 7'd2},
    '{KIND_RSVD6,  7'd127, 32'hFFFF_FFFF, 1'b1, STATUS_BADPOS, 6'd0, 32'h0, 7'd2},
    '{KIND_RSVD7,  7'd0,   32'h8000_0000, 1'b1, STATUS_BADPOS, 6'd0, 32'h0, 7'd2},
    // clear, then a search on the empty table
    '{KIND_CLEAR,  7'd0,   32'h0000_0000, 1'b1, STATUS_OK,   6'd0, 32'h0, 7'd0},
    '{KIND_SEARCH, 7'd0,   32'hFFFF_FFFF, 1'b1, STATUS_MISS, 6'd0, 32'h0, 7'd0}
  };

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    res_t        typed_want;
    logic [2:0]  k;
    logic [6:0]  p;
    logic [31:0] v;
    int          pick;
    int          ph;
    int          phase_end;
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.kind     = KIND_CLEAR;
    req_ch.position = '0;
    req_ch.value    = '0;
    table_len       = 0;
    tx_idle_pct     = 34;
    rx_idle_pct     = 53;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      typed_want.status      = dir_rows[i].status;
      typed_want.found_index = dir_rows[i].found;
      typed_want.read_value  = dir_rows[i].rdval;
      typed_want.count       = dir_rows[i].count;
      send_item(dir_rows[i].kind, dir_rows[i].pos, dir_rows[i].val,
                dir_rows[i].typed, typed_want);
    end

    // three phases: receiver-heavy idling, sender-heavy idling, none at all
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 34; rx_idle_pct = 53; end
        1: begin tx_idle_pct = 53; rx_idle_pct = 34; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      phase_end = N_DIRECTED + (ph + 1) * RANDOM_ITEMS / 3;

      // each phase starts by filling the table to the brim
      while (table_len < DEPTH)
        send_item(KIND_INSERT, 7'($urandom_range(1, table_len + 1)), pick_value());
      // full-table probes: valid positions hit the full check, one beyond is a bad position
      send_item(KIND_INSERT, 7'd1, pick_value());
      send_item(KIND_INSERT, 7'(DEPTH + 1), pick_value());
      send_item(KIND_INSERT, 7'(DEPTH + 2), pick_value());
      send_item(KIND_READ, 7'(DEPTH - 1), $urandom);
      send_item(KIND_READ, 7'(DEPTH), $urandom);
      send_item(KIND_SEARCH, 7'($urandom_range(0, 127)), table_mem[DEPTH - 1]);
      send_item(KIND_DELETE, 7'(DEPTH), $urandom);

      // in the quiet phase the receiver stops for a long while to back the block up
      if (ph == 2) hold_request = 1'b1;

      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        p = 7'($urandom_range(0, 127));
        v = pick_value();
        if (pick < 30) begin
          k = KIND_INSERT;
          if ($urandom_range(0, 99) < 85) p = 7'($urandom_range(1, table_len + 1));
        end else if (pick < 50) begin
          k = KIND_DELETE;
          if (table_len > 0 && $urandom_range(0, 99) < 85)
            p = 7'($urandom_range(1, table_len));
        end else if (pick < 70) begin
          k = KIND_SEARCH;
          if (table_len > 0 && $urandom_range(0, 99) < 70)
            v = table_mem[$urandom_range(0, table_len - 1)];
        end else if (pick < 90) begin
          k = KIND_READ;
          if (table_len > 0 && $urandom_range(0, 99) < 85)
            p = 7'($urandom_range(0, table_len - 1));
        end else if (pick < 92) begin
          k = KIND_CLEAR;
        end else begin
          // noise: any kind, any position, any value
          k = 3'($urandom_range(0, 7));
          v = $urandom;
        end
        send_item(k, p, v);
      end
    end

    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    // a search takes a full rotation; give any stray response time to show
    repeat (DEPTH + 8) @(posedge clk);

    $display("covered %0d requests and %0d checked responses over three idling phases",
             items_sent, rsp_checked);
    $display("%0d full-table rejects, %0d search hits, %0d long receiver hold-off(s)",
             full_rejects, search_hits, holds_done);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: random back-pressure plus one long hold-off
  // ---------------------------------------------------------------------------
  initial begin : receiver
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // response checker: every transfer is matched against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : rsp_check
    res_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("response with nothing outstanding: status %0h count %0h",
               rsp_ch.status, rsp_ch.count);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        check_field("status", 32'(want.status), 32'(rsp_ch.status));
        check_field("found_index", 32'(want.found_index), 32'(rsp_ch.found_index));
        check_field("read_value", want.read_value, rsp_ch.read_value);
        check_field("count", 32'(want.count), 32'(rsp_ch.count));
        rsp_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without a transfer on either channel ends the run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $error("no transfer for %0d cycles, %0d responses outstanding",
             stall_cycles, pending_rsp.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
